// ===== rtl/oid_arc_ber_encoder_assert.svh =====
// Assertion macros used by the back part of the encoder.
// Each macro takes a label, a condition on the current cycle, the
// consequence and the message to report.
`ifndef OID_ARC_BER_ENCODER_ASSERT_SVH
`define OID_ARC_BER_ENCODER_ASSERT_SVH

// The consequence must hold in the same cycle.
`define OAB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequence must hold in the following cycle.
`define OAB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/oab_pkg.sv =====
`timescale 1ns / 1ps

package oab_pkg;

  // Arc width that is actually used; upper input bits are ignored.
  localparam int ARC_BITS = 32;
  // 40 * first + second stays below 41 * 2^ARC_BITS, so six more bits.
  localparam int CMB_BITS = ARC_BITS + 6;
  // Number of 7-bit groups that cover the combined value.
  localparam int MAX_GROUPS = (CMB_BITS + 6) / 7;
  localparam int PAD_BITS = 7 * MAX_GROUPS;
  localparam int GRP_W = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;

  // Command queue between the front and back parts.
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // Result status codes.
  typedef enum logic [1:0] {
    ST_BYTE      = 2'd0,
    ST_SHORT     = 2'd1,
    ST_ZERO_LAST = 2'd2
  } status_e;

  // Position of the next arc within the identifier.
  typedef enum logic [2:0] {
    POS_FIRST  = 3'b001,
    POS_SECOND = 3'b010,
    POS_LATER  = 3'b100
  } arc_pos_e;

  typedef struct packed {
    logic [31:0] arc_value;
    logic        end_of_oid;
  } arc_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] status;
    logic       last_of_oid;
  } byte_out_t;

  // One unit of work for the back part: a value to encode or an error.
  typedef struct packed {
    status_e               kind;
    logic [CMB_BITS-1:0]   value;
    logic                  is_final;
  } cmd_t;

endpackage

// ===== rtl/oab_cmd_fifo.sv =====
`timescale 1ns / 1ps

module oab_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  oab_pkg::cmd_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output oab_pkg::cmd_t pop_data_o
);
  import oab_pkg::*;

  cmd_t                  mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_W-1:0] cnt_q, cnt_d;
  logic                  do_push, do_pop;

  assign full_o     = (cnt_q == FIFO_CNT_W'(FIFO_DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/oab_front.sv =====
`timescale 1ns / 1ps

module oab_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  oab_pkg::arc_in_t in_data_i,
  output logic             cmd_push_o,
  output oab_pkg::cmd_t    cmd_o,
  input  logic             cmd_full_i
);
  import oab_pkg::*;

  arc_pos_e            pos_q, pos_d;
  logic [ARC_BITS-1:0] held_q, held_d;
  logic [ARC_BITS-1:0] arc;
  logic [CMB_BITS-1:0] combined;
  logic                accept;
  cmd_t                cmd;
  logic                has_cmd;

  assign in_ready_o = !cmd_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign arc        = in_data_i.arc_value[ARC_BITS-1:0];

  // 40 * first = 32 * first + 8 * first, one three-input add.
  assign combined = (CMB_BITS'(held_q) << 5) + (CMB_BITS'(held_q) << 3) + CMB_BITS'(arc);

  // Classify the arc and choose the next position.
  always_comb begin
    cmd.kind     = ST_BYTE;
    cmd.value    = CMB_BITS'(arc);
    cmd.is_final = in_data_i.end_of_oid;
    has_cmd      = 1'b1;
    pos_d        = pos_q;
    held_d       = held_q;
    case (pos_q)
      POS_FIRST: begin
        if (in_data_i.end_of_oid) begin
          cmd.kind  = ST_SHORT;
          cmd.value = '0;
        end else begin
          has_cmd = 1'b0;
          held_d  = arc;
          pos_d   = POS_SECOND;
        end
      end
      POS_SECOND: begin
        cmd.value = combined;
        pos_d     = POS_LATER;
      end
      default: begin
        pos_d = POS_LATER;
      end
    endcase
    // A zero final arc replaces its bytes with an error item.
    if (pos_q != POS_FIRST && in_data_i.end_of_oid && arc == '0) begin
      cmd.kind  = ST_ZERO_LAST;
      cmd.value = '0;
    end
    if (in_data_i.end_of_oid) begin
      pos_d  = POS_FIRST;
      held_d = '0;
    end
  end

  assign cmd_push_o = accept && has_cmd;
  assign cmd_o      = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= POS_FIRST;
      held_q <= '0;
    end else if (accept) begin
      pos_q  <= pos_d;
      held_q <= held_d;
    end
  end

endmodule

// ===== rtl/oab_back.sv =====
`timescale 1ns / 1ps

module oab_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_empty_i,
  input  oab_pkg::cmd_t      cmd_i,
  output logic               cmd_pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output oab_pkg::byte_out_t out_data_o
);
  import oab_pkg::*;

  `include "oid_arc_ber_encoder_assert.svh"

  logic                busy_q;
  status_e             kind_q;
  logic                final_q;
  logic [PAD_BITS-1:0] val_q;
  logic [GRP_W-1:0]    idx_q, idx_d;
  logic [PAD_BITS-1:0] cmd_val_pad;
  logic                emit, emit_last;
  logic [6:0]          grp;
  byte_out_t           next_out;
  logic                out_valid_q;
  byte_out_t           out_q;

  assign cmd_val_pad = PAD_BITS'(cmd_i.value);

  // Index of the most significant nonzero group of the new value.
  always_comb begin
    idx_d = '0;
    for (int g = 1; g < MAX_GROUPS; g++) begin
      if ((cmd_val_pad >> (7 * g)) != '0) begin
        idx_d = GRP_W'(g);
      end
    end
  end

  // One byte leaves whenever a command is held and the output register is free or being drained.
  assign emit      = busy_q && (!out_valid_q || out_ready_i);
  assign emit_last = emit && (idx_q == '0);
  assign cmd_pop_o = !cmd_empty_i && (!busy_q || emit_last);

  // Select the current 7-bit group.
  always_comb begin
    grp = val_q[6:0];
    for (int g = 1; g < MAX_GROUPS; g++) begin
      if (idx_q == GRP_W'(g)) begin
        grp = val_q[7*g +: 7];
      end
    end
  end

  // Form the result item.
  always_comb begin
    if (kind_q == ST_BYTE) begin
      next_out.out_byte    = {(idx_q != '0), grp};
      next_out.status      = ST_BYTE;
      next_out.last_of_oid = final_q && (idx_q == '0);
    end else begin
      next_out.out_byte    = '0;
      next_out.status      = kind_q;
      next_out.last_of_oid = 1'b1;
    end
  end

  // Command register and group counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (cmd_pop_o) begin
      busy_q <= 1'b1;
      idx_q  <= (cmd_i.kind == ST_BYTE) ? idx_d : '0;
    end else if (emit_last) begin
      busy_q <= 1'b0;
    end else if (emit) begin
      idx_q <= idx_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      kind_q  <= cmd_i.kind;
      final_q <= cmd_i.is_final;
      val_q   <= cmd_val_pad;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= next_out;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `OAB_ASSERT_NOW(a_err_single, busy_q && kind_q != ST_BYTE, idx_q == '0, "error command with more than one group")
  `OAB_ASSERT_NOW(a_idx_range, busy_q, idx_q < GRP_W'(MAX_GROUPS), "group index out of range")
  `OAB_ASSERT_NEXT(a_err_is_last, emit && kind_q != ST_BYTE, out_valid_q && out_q.last_of_oid, "error item not marked last")

endmodule

// ===== rtl/oid_arc_ber_encoder.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Handshake                    Payload
// in        input      in_valid_i / in_ready_o      in_data_i  (arc_value, end_of_oid)
// out       output     out_valid_o / out_ready_i    out_data_o (out_byte, status, last_of_oid)
//
// The front part takes one arc per cycle while the two-entry command queue has room.
// The back part emits one byte per cycle unless the output stalls; an accepted arc yields
// zero to six content bytes or one error item, one byte for each 7-bit group of its value.
// An accepted arc passes through the command queue, the back part's command register and the output register.
// Reset is asynchronous and clears the arc position, the held first arc and the queue.
// A stalled output holds the back part; a full queue then holds the input.

module oid_arc_ber_encoder (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  oab_pkg::arc_in_t   in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output oab_pkg::byte_out_t out_data_o
);
  import oab_pkg::*;

  logic cmd_push, cmd_full, cmd_pop, cmd_empty;
  cmd_t cmd_wr, cmd_rd;

  oab_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_wr),
    .cmd_full_i (cmd_full)
  );

  oab_cmd_fifo u_cmd_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (cmd_push),
    .push_data_i (cmd_wr),
    .full_o      (cmd_full),
    .pop_i       (cmd_pop),
    .empty_o     (cmd_empty),
    .pop_data_o  (cmd_rd)
  );

  oab_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd_rd),
    .cmd_pop_o   (cmd_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== test/tb_oid_arc_ber_encoder.sv =====
`timescale 1ns / 1ps

module tb_oid_arc_ber_encoder;
  import oab_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int RANDOM_ARCS = 360;
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLD_AFTER = 150;
  localparam int HOLD_CYCLES = 400;
  localparam int MAX_GROUPS_EXP = 6;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  arc_in_t   in_data_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  byte_out_t out_data_o;

  // Arcs waiting to be offered, and content bytes the encoder still owes.
  arc_in_t   arc_queue[$];
  byte_out_t byte_expect_q[$];

  // Shadow state of the encoder.
  logic [31:0] first_arc_hold = '0;
  arc_pos_e    arc_pos = POS_FIRST;

  int mismatch_count = 0;
  int cycle_count = 0;
  int arcs_accepted = 0;
  int oids_done = 0;
  int bytes_checked = 0;
  int errors_checked = 0;
  int input_stalls = 0;
  int send_gap = 0;
  int recv_gap = 0;
  int hold_left = 0;
  logic hold_done = 1'b0;
  logic no_idle = 1'b0;
  logic next_valid;
  logic next_ready;
  byte_out_t exp_byte;

  oid_arc_ber_encoder uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  // Mismatch reporting: one line per failure.
  task automatic report_mismatch(input string what, input longint got_v, input longint exp_v);
    $display("MISMATCH at cycle %0d: %s got %0h expected %0h", cycle_count, what, got_v, exp_v);
    mismatch_count++;
  endtask

  // Mostly short gaps, a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Arc values spread over small values, group boundaries and full width.
  function automatic logic [31:0] rand_arc();
    int k;
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 3);
      1: return $urandom_range(0, 127);
      2: begin
        k = $urandom_range(1, 4);
        return (32'd1 << (7 * k)) - 32'($urandom_range(0, 1));
      end
      3: return $urandom_range(0, 16383);
      default: return $urandom();
    endcase
  endfunction

  task automatic add_arc(input logic [31:0] v, input logic fin);
    arc_in_t a;
    a.arc_value = v;
    a.end_of_oid = fin;
    arc_queue.push_back(a);
  endtask

  // Split a value into big-endian base-128 groups, continuation bit on all but the last.
  task automatic push_base128(input logic [37:0] v, input logic fin);
    int groups;
    int k;
    logic [37:0] t;
    logic [37:0] sh;
    byte_out_t b;
    groups = 1;
    t = v >> 7;
    while (t != 0 && groups < MAX_GROUPS_EXP) begin
      groups++;
      t = t >> 7;
    end
    for (k = 0; k < groups; k++) begin
      sh = v >> (7 * (groups - 1 - k));
      b.out_byte = {(k != groups - 1), sh[6:0]};
      b.status = ST_BYTE;
      b.last_of_oid = (k == groups - 1) && fin;
      byte_expect_q.push_back(b);
    end
  endtask

  // Work out the bytes or error that one accepted arc causes.
  task automatic encode_arc(input arc_in_t a);
    logic [31:0] arc;
    logic [37:0] combined;
    byte_out_t e;
    arc = a.arc_value & 32'((64'd1 << ARC_BITS) - 1);
    e.out_byte = 8'h00;
    e.last_of_oid = 1'b1;
    if (arc_pos == POS_FIRST) begin
      if (a.end_of_oid) begin
        e.status = ST_SHORT;
        byte_expect_q.push_back(e);
      end else begin
        first_arc_hold = arc;
        arc_pos = POS_SECOND;
      end
    end else if (a.end_of_oid && arc == 0) begin
      e.status = ST_ZERO_LAST;
      byte_expect_q.push_back(e);
    end else begin
      if (arc_pos == POS_SECOND) begin
        combined = 38'(first_arc_hold) * 38'd40 + 38'(arc);
      end else begin
        combined = 38'(arc);
      end
      push_base128(combined, a.end_of_oid);
      arc_pos = POS_LATER;
    end
    if (a.end_of_oid) begin
      first_arc_hold = '0;
      arc_pos = POS_FIRST;
    end
  endtask

  // Sender: offers the pending arcs with random gaps between transfers.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_ready_o) input_stalls++;
      if (in_valid_i && in_ready_o) begin
        encode_arc(arc_queue[0]);
        if (arc_queue[0].end_of_oid) oids_done++;
        arc_queue.pop_front();
        arcs_accepted <= arcs_accepted + 1;
        send_gap = no_idle ? 0 : pick_gap();
        if (arcs_accepted % 40 == 39) no_idle <= ($urandom_range(0, 3) == 0);
      end
      if (!(in_valid_i && !in_ready_o)) begin
        if (send_gap > 0) begin
          send_gap--;
          next_valid = 1'b0;
        end else if (arc_queue.size() > 0) begin
          in_data_i <= arc_queue[0];
          next_valid = 1'b1;
        end else begin
          next_valid = 1'b0;
        end
        in_valid_i <= next_valid;
      end
    end
  end

  // One long receiver hold-off once the run is under way, so the queue fills up.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && arcs_accepted >= HOLD_AFTER) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Receiver: checks each transfer against the oldest expected byte.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (byte_expect_q.size() == 0) begin
          report_mismatch("unexpected result, byte", out_data_o.out_byte, 0);
        end else begin
          exp_byte = byte_expect_q.pop_front();
          if (out_data_o.out_byte !== exp_byte.out_byte)
            report_mismatch("out_byte", out_data_o.out_byte, exp_byte.out_byte);
          if (out_data_o.status !== exp_byte.status)
            report_mismatch("status", out_data_o.status, exp_byte.status);
          if (out_data_o.last_of_oid !== exp_byte.last_of_oid)
            report_mismatch("last_of_oid", out_data_o.last_of_oid, exp_byte.last_of_oid);
          if (exp_byte.status == ST_BYTE) bytes_checked++;
          else errors_checked++;
        end
      end
      if (hold_left != 0) begin
        next_ready = 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        next_ready = 1'b0;
      end else begin
        next_ready = 1'b1;
        if (!no_idle && $urandom_range(0, 4) == 0) recv_gap = pick_gap();
      end
      out_ready_i <= next_ready;
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("oid_arc_ber_encoder test failed");
      $finish;
    end
  end

  initial begin
    int n_random;
    int len;
    int kind;
    int i;
    logic [31:0] v;
    logic fin;

    // Directed identifiers: error cases, full-width arcs and group boundaries.
    add_arc(32'd5, 1'b1);
    add_arc(32'd0, 1'b1);
    add_arc(32'd0, 1'b0);
    add_arc(32'd0, 1'b1);
    add_arc(32'd1, 1'b0);
    add_arc(32'd2, 1'b0);
    add_arc(32'd840, 1'b0);
    add_arc(32'd113549, 1'b1);
    add_arc(32'd2, 1'b0);
    add_arc(32'hFFFF_FFFF, 1'b1);
    add_arc(32'hFFFF_FFFF, 1'b0);
    add_arc(32'hFFFF_FFFF, 1'b1);
    add_arc(32'd1, 1'b0);
    add_arc(32'd3, 1'b0);
    add_arc(32'd0, 1'b0);
    add_arc(32'd0, 1'b1);
    add_arc(32'd1, 1'b0);
    add_arc(32'd1, 1'b0);
    add_arc(32'h7F, 1'b0);
    add_arc(32'h80, 1'b0);
    add_arc(32'h3FFF, 1'b0);
    add_arc(32'h4000, 1'b1);

    // Random identifiers: mostly well formed, some single arcs, zero endings and noise.
    n_random = 0;
    while (n_random < RANDOM_ARCS) begin
      kind = $urandom_range(0, 19);
      if (kind == 0) begin
        add_arc(rand_arc(), 1'b1);
        n_random++;
      end else if (kind == 1) begin
        len = $urandom_range(1, 4);
        for (i = 0; i < len; i++) begin
          add_arc($urandom(), 1'($urandom_range(0, 1)));
          n_random++;
        end
      end else begin
        len = $urandom_range(2, 7);
        for (i = 0; i < len; i++) begin
          fin = (i == len - 1);
          v = rand_arc();
          if (i == 0 && $urandom_range(0, 3) != 0) v = $urandom_range(0, 2);
          if (fin && kind == 2) v = 32'd0;
          if (!fin && i > 1 && $urandom_range(0, 9) == 0) v = 32'd0;
          add_arc(v, fin);
          n_random++;
        end
      end
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (arc_queue.size() != 0 || byte_expect_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("Ran %0d arcs in %0d identifiers: %0d content bytes and %0d error results checked.",
             arcs_accepted, oids_done, bytes_checked, errors_checked);
    $display("Input was held back for %0d cycles, including one receiver hold-off of %0d cycles.",
             input_stalls, HOLD_CYCLES);
    if (mismatch_count == 0) begin
      $display("oid_arc_ber_encoder test passed");
    end else begin
      $display("oid_arc_ber_encoder test failed");
    end
    $finish;
  end

endmodule
